// ===== hdl/assert_macros.svh =====
// shared assertion macros for the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/cdq_pkg.sv =====
package cdq_pkg;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;
   localparam int CAP_DEFAULT = 16;

   // operation codes on req_tuser
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

   // status codes on rsp_tuser
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // result fields that travel beside the memory read
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                empty;
      logic                full;
      logic [CAP_W-1:0]    occupancy;
   } rsp_meta_type;

endpackage

// ===== hdl/cdq_mem.sv =====
module cdq_mem #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/circular_deque_top.sv =====
// Double-ended queue in a circular buffer of DEPTH entries of DATA_WIDTH bits. Each request
// transaction carries one operation in req_tuser (push front/rear, pop front/rear, peek
// front/rear) and yields exactly one response transaction with the element read (0 after a push,
// an unused kind or on underflow), a status in rsp_tuser and the empty flag, full flag and
// occupancy after the operation. A new transaction is taken every cycle while rsp_tready stays
// high; with the response side stalled the read stage and the output register hold two
// transactions and req_tready then drops until the output register drains. A response passes
// first through the synchronous read of the storage memory and then through the output
// register. The storage memory has one write and one read port; every operation uses at most one
// of them, and a read in the cycle after a write to the same entry already sees the new data.
// Writing csr_wdata with csr_we sets the capacity (0 is taken as 1, values above DEPTH as DEPTH)
// and empties the deque; do this only while no transaction is in flight.
`include "assert_macros.svh"

module circular_deque_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // capacity register
   input  logic                          csr_we,
   input  logic [cdq_pkg::CAP_W-1:0]     csr_wdata,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cdq_pkg::VALUE_W-1:0]   req_tdata,  // [31:0] value
   input  logic [cdq_pkg::KIND_W-1:0]    req_tuser,  // [2:0] kind
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,  // [31:0] data, [32] empty_res,
                                                     // [33] full_res, [38:34] occupancy,
                                                     // [39] zero
   output logic [cdq_pkg::STATUS_W-1:0]  rsp_tuser   // [1:0] status
);

   import cdq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   // wide enough to compare an index plus one against the capacity
   localparam int PW = ((IW > CAP_W) ? IW : CAP_W) + 1;
   localparam logic [CAP_W-1:0] CAP_RESET =
      CAP_W'((DEPTH < CAP_DEFAULT) ? DEPTH : CAP_DEFAULT);

   // deque state
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] fill_ff, fill_in;
   logic [IW-1:0]    front_ff, front_in;
   logic [IW-1:0]    rear_ff, rear_in;

   // read stage and output register
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_rd_ff;
   rsp_meta_type     s1_meta_ff;
   rsp_meta_type     meta_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_data_ff;
   rsp_meta_type     rsp_meta_ff;

   // memory ports
   logic                  mem_we, mem_re, rd_flag;
   logic [IW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   logic             accept, out_free, s1_move;
   logic             is_empty, is_full;
   logic [IW-1:0]    cap_m1, front_back, front_fwd, rear_back, rear_fwd;
   logic [PW-1:0]    front_inc, rear_inc;
   logic [CAP_W-1:0] cfg_cap;
   logic [STATUS_W-1:0] status;

   // handshake: the read stage empties whenever the output register can take it
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // pointer wrap at the configured capacity
   assign cap_m1     = IW'(capacity_ff - CAP_W'(1));
   assign front_inc  = PW'(front_ff) + PW'(1);
   assign rear_inc   = PW'(rear_ff) + PW'(1);
   assign front_back = (front_ff == '0) ? cap_m1 : front_ff - IW'(1);
   assign rear_back  = (rear_ff == '0) ? cap_m1 : rear_ff - IW'(1);
   assign front_fwd  = (front_inc >= PW'(capacity_ff)) ? '0 : IW'(front_inc);
   assign rear_fwd   = (rear_inc >= PW'(capacity_ff)) ? '0 : IW'(rear_inc);

   assign is_empty = (fill_ff == '0);
   assign is_full  = (fill_ff >= capacity_ff);

   // clamp a written capacity into 1..DEPTH
   always_comb begin
      cfg_cap = csr_wdata;
      if (csr_wdata == '0) begin
         cfg_cap = CAP_W'(1);
      end else if (32'(csr_wdata) > DEPTH) begin
         cfg_cap = CAP_W'(DEPTH);
      end
   end

   // capacity write or operation decode: pointer update, at most one memory access, status
   always_comb begin
      front_in    = front_ff;
      rear_in     = rear_ff;
      fill_in     = fill_ff;
      capacity_in = capacity_ff;
      status      = ST_OK;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      rd_flag     = 1'b0;
      mem_waddr   = '0;
      mem_raddr   = front_ff;
      mem_wdata   = DATA_WIDTH'(req_tdata);
      if (csr_we) begin
         // capacity write empties the deque
         capacity_in = cfg_cap;
         front_in    = '0;
         rear_in     = '0;
         fill_in     = '0;
      end else if (accept) begin
         unique case (req_tuser)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (is_full) begin
                  status = ST_OVERFLOW;
               end else if (is_empty) begin
                  // first element always lands in entry zero
                  front_in  = '0;
                  rear_in   = '0;
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  fill_in   = CAP_W'(1);
               end else if (req_tuser == KIND_PUSH_FRONT) begin
                  front_in  = front_back;
                  mem_we    = 1'b1;
                  mem_waddr = front_back;
                  fill_in   = fill_ff + CAP_W'(1);
               end else begin
                  rear_in   = rear_fwd;
                  mem_we    = 1'b1;
                  mem_waddr = rear_fwd;
                  fill_in   = fill_ff + CAP_W'(1);
               end
            end
            KIND_POP_FRONT, KIND_POP_REAR: begin
               if (is_empty) begin
                  status = ST_UNDERFLOW;
               end else begin
                  mem_re    = 1'b1;
                  rd_flag   = 1'b1;
                  mem_raddr = (req_tuser == KIND_POP_FRONT) ? front_ff : rear_ff;
                  if (fill_ff == CAP_W'(1)) begin
                     // last element gone, pointers home
                     front_in = '0;
                     rear_in  = '0;
                     fill_in  = '0;
                  end else begin
                     if (req_tuser == KIND_POP_FRONT) begin
                        front_in = front_fwd;
                     end else begin
                        rear_in = rear_back;
                     end
                     fill_in = fill_ff - CAP_W'(1);
                  end
               end
            end
            KIND_PEEK_FRONT, KIND_PEEK_REAR: begin
               if (is_empty) begin
                  status = ST_UNDERFLOW;
               end else begin
                  mem_re    = 1'b1;
                  rd_flag   = 1'b1;
                  mem_raddr = (req_tuser == KIND_PEEK_FRONT) ? front_ff : rear_ff;
               end
            end
            default: begin
               // unused kinds only report the flags
            end
         endcase
      end
   end

   // flags reported after the operation
   always_comb begin
      meta_in.status    = status;
      meta_in.empty     = (fill_in == '0);
      meta_in.full      = (fill_in == capacity_ff);
      meta_in.occupancy = fill_in;
   end

   cdq_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         fill_ff      <= '0;
         front_ff     <= '0;
         rear_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         fill_ff      <= fill_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: read stage side info, then the response register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_ff   <= rd_flag;
         s1_meta_ff <= meta_in;
      end
      if (s1_move) begin
         rsp_data_ff <= s1_rd_ff ? VALUE_W'(mem_rdata) : '0;
         rsp_meta_ff <= s1_meta_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_meta_ff.occupancy, rsp_meta_ff.full,
                        rsp_meta_ff.empty, rsp_data_ff};
   assign rsp_tuser  = rsp_meta_ff.status;

   `ASSERT_HOLDS(a_fill_in_cap, clock, reset, fill_ff <= capacity_ff,
      "occupancy above capacity")
   `ASSERT_HOLDS(a_cap_range, clock, reset,
      (capacity_ff != '0) && (32'(capacity_ff) <= DEPTH), "capacity out of range")
   `ASSERT_HOLDS(a_empty_home, clock, reset,
      (fill_ff != '0) || ((front_ff == '0) && (rear_ff == '0)),
      "empty deque with pointers away from entry zero")
   `ASSERT_NEVER(a_ovf_not_full, clock, reset,
      rsp_tvalid && (rsp_tuser == ST_OVERFLOW) && !rsp_meta_ff.full,
      "overflow reported on a deque that is not full")
   `ASSERT_NEVER(a_udf_not_empty, clock, reset,
      rsp_tvalid && (rsp_tuser == ST_UNDERFLOW) && !rsp_meta_ff.empty,
      "underflow reported on a deque that is not empty")

endmodule

// ===== verif/cdq_checker.sv =====
// watches both channels and the capacity port, keeps its own copy of the deque and
// compares every response transaction against the oldest outstanding prediction
module cdq_checker
   import cdq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CAP_W-1:0]    csr_wdata,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,
   input  logic [KIND_W-1:0]   req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [39:0]         rsp_tdata,
   input  logic [STATUS_W-1:0] rsp_tuser,
   output int                  fail_count,
   output int                  outstanding
);

   localparam int PTR_W = $clog2(DEPTH);

   typedef struct packed {
      logic [VALUE_W-1:0]  data;
      logic [STATUS_W-1:0] status;
      logic                empty;
      logic                full;
      logic [CAP_W-1:0]    occupancy;
   } deque_outcome_type;

   logic [VALUE_W-1:0] slot_mem [DEPTH];
   logic [PTR_W-1:0]   head;
   logic [PTR_W-1:0]   tail;
   logic [CAP_W-1:0]   fill;
   logic [CAP_W-1:0]   cap_now;
   deque_outcome_type  awaited_q [$];
   int                 errors;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (int'(p) + 1 >= int'(cap_now)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(cap_now - 1'b1) : p - 1'b1;
   endfunction

   // capacity write: clamp into 1..DEPTH and empty the deque
   task automatic load_capacity(input logic [CAP_W-1:0] c);
      if (c == '0)
         cap_now = CAP_W'(1);
      else if (int'(c) > DEPTH)
         cap_now = CAP_W'(DEPTH);
      else
         cap_now = c;
      head = '0;
      tail = '0;
      fill = '0;
   endtask

   function automatic deque_outcome_type deque_apply(input logic [KIND_W-1:0] kind,
                                                     input logic [VALUE_W-1:0] value);
      deque_outcome_type r;
      r.data   = '0;
      r.status = ST_OK;
      unique case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
            if (fill >= cap_now) begin
               r.status = ST_OVERFLOW;
            end else if (fill == '0) begin
               head        = '0;
               tail        = '0;
               slot_mem[0] = value;
               fill        = CAP_W'(1);
            end else if (kind == KIND_PUSH_FRONT) begin
               head           = ptr_prev(head);
               slot_mem[head] = value;
               fill           = fill + 1'b1;
            end else begin
               tail           = ptr_next(tail);
               slot_mem[tail] = value;
               fill           = fill + 1'b1;
            end
         end
         KIND_POP_FRONT, KIND_POP_REAR: begin
            if (fill == '0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               r.data = (kind == KIND_POP_FRONT) ? slot_mem[head] : slot_mem[tail];
               if (fill == CAP_W'(1)) begin
                  head = '0;
                  tail = '0;
                  fill = '0;
               end else begin
                  if (kind == KIND_POP_FRONT)
                     head = ptr_next(head);
                  else
                     tail = ptr_prev(tail);
                  fill = fill - 1'b1;
               end
            end
         end
         KIND_PEEK_FRONT, KIND_PEEK_REAR: begin
            if (fill == '0)
               r.status = ST_UNDERFLOW;
            else
               r.data = (kind == KIND_PEEK_FRONT) ? slot_mem[head] : slot_mem[tail];
         end
         default: ;
      endcase
      r.empty     = (fill == '0);
      r.full      = (fill == cap_now);
      r.occupancy = fill;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: response %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      deque_outcome_type want;
      if (reset) begin
         cap_now = CAP_W'((DEPTH < CAP_DEFAULT) ? DEPTH : CAP_DEFAULT);
         head    = '0;
         tail    = '0;
         fill    = '0;
         awaited_q.delete();
      end else begin
         // responses are checked before this edge's request is predicted
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none actual data %0h status %0h",
                        $time, rsp_tdata[31:0], rsp_tuser);
            end else begin
               want = awaited_q.pop_front();
               check_field("data", want.data, rsp_tdata[31:0]);
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("empty", 32'(want.empty), 32'(rsp_tdata[32]));
               check_field("full", 32'(want.full), 32'(rsp_tdata[33]));
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_tdata[38:34]));
               check_field("pad", 32'd0, 32'(rsp_tdata[39]));
            end
         end
         if (csr_we)
            load_capacity(csr_wdata);
         if (req_tvalid && req_tready)
            awaited_q.push_back(deque_apply(req_tuser, req_tdata));
      end
      fail_count  <= errors;
      outstanding <= awaited_q.size();
   end

endmodule

// ===== verif/tb.sv =====
// stimulus and verdict for the circular deque; all prediction lives in cdq_checker
module tb;
   import cdq_pkg::*;

   // kinds the block treats as no operation
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   localparam int PHASES     = 11;
   localparam int PHASE_ITEMS = 166;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [CAP_W-1:0]    csr_wdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata;
   logic [KIND_W-1:0]   req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [39:0]         rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   // no idling on either side once this is set
   logic                calm = 1'b0;
   int                  stall_left = 0;
   int                  fail_count;
   int                  outstanding;

   always #6 clock = ~clock;

   circular_deque_top #(
      .DEPTH      (16),
      .DATA_WIDTH (32)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cdq_checker #(
      .DEPTH (16)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // response backpressure: random stall bursts between ready runs
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_tready) begin
         if ($urandom_range(0, 99) < 15) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 12);
         end
      end else begin
         // ready run, sometimes long enough to leave the block unthrottled
         rsp_tready <= 1'b1;
         stall_left = $urandom_range(0, 40);
      end
   end

   // occasional gap on the request side after a transaction
   task automatic idle_gap();
      if (!calm && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // present one request and hold it until the handshake
   task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      idle_gap();
   endtask

   // capacity write only once the pipeline has drained
   task automatic set_capacity(input logic [CAP_W-1:0] c);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // spare wait past the two-stage response pipeline
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= c;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // random traffic in modes: push-heavy to reach full, pop-heavy to drain, mixed
   task automatic random_phase(input int count);
      int                 mode_left;
      int                 push_pct;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      mode_left = 0;
      push_pct  = 50;
      for (int i = 0; i < count; i++) begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         mode_left--;
         if ($urandom_range(0, 99) < 3)
            kind = KIND_W'($urandom_range(KIND_SPARE_A, KIND_SPARE_B));
         else if ($urandom_range(0, 99) < push_pct)
            kind = KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_PUSH_REAR));
         else
            kind = KIND_W'($urandom_range(KIND_POP_FRONT, KIND_PEEK_REAR));
         // mostly random words, some sign and magnitude extremes
         case ($urandom_range(0, 19))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7fff_ffff;
            2:       value = 32'h0000_0000;
            3:       value = 32'hffff_ffff;
            default: value = $urandom;
         endcase
         issue_op(kind, value);
      end
   endtask

   initial begin
      logic [CAP_W-1:0] caps [PHASES];

      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_PUSH_FRONT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty deque at the reset capacity: every read kind underflows
      issue_op(KIND_POP_FRONT, 32'h1234_5678);
      issue_op(KIND_POP_REAR, 32'h0);
      issue_op(KIND_PEEK_FRONT, 32'hffff_ffff);
      issue_op(KIND_PEEK_REAR, 32'h0);
      issue_op(KIND_SPARE_A, 32'hdead_beef);
      issue_op(KIND_SPARE_B, 32'h0);
      // push into empty lands in slot 0, then both ends grow with extreme values
      issue_op(KIND_PUSH_FRONT, 32'h7fff_ffff);
      issue_op(KIND_PUSH_REAR, 32'h8000_0000);
      issue_op(KIND_PUSH_FRONT, 32'h0000_0000);
      issue_op(KIND_PUSH_REAR, 32'hffff_ffff);
      issue_op(KIND_PEEK_FRONT, 32'h0);
      issue_op(KIND_PEEK_REAR, 32'h0);
      issue_op(KIND_SPARE_B, 32'hffff_ffff);
      // drain from both ends down through the last element
      issue_op(KIND_POP_REAR, 32'h0);
      issue_op(KIND_POP_FRONT, 32'h0);
      issue_op(KIND_PEEK_REAR, 32'h0);
      issue_op(KIND_POP_FRONT, 32'h0);
      issue_op(KIND_POP_REAR, 32'h0);
      issue_op(KIND_PEEK_FRONT, 32'h0);

      // capacity zero is taken as one: full after one push, then overflow
      set_capacity(5'd0);
      issue_op(KIND_PUSH_REAR, 32'ha5a5_a5a5);
      issue_op(KIND_PUSH_FRONT, 32'h5a5a_5a5a);
      issue_op(KIND_PEEK_REAR, 32'h0);
      issue_op(KIND_POP_REAR, 32'h0);

      // capacity sweep: above-range clamp, tiny, full size, random sizes
      caps = '{5'd31, 5'd2, 5'd3, 5'd16, 5'd17, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0, 5'd16};
      for (int p = 6; p <= 8; p++)
         caps[p] = CAP_W'($urandom_range(1, 16));
      caps[9] = CAP_W'($urandom_range(0, 31));

      for (int p = 0; p < PHASES; p++) begin
         // final phase runs with no idling on either side
         if (p == PHASES - 1)
            calm <= 1'b1;
         set_capacity(caps[p]);
         random_phase(PHASE_ITEMS);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("circular_deque_top regression: pass");
      else
         $display("circular_deque_top regression: fail");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5000000;
      $display("circular_deque_top regression: fail");
      $finish;
   end

endmodule

// ===== circular_deque_top.f =====
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_mem.sv
hdl/circular_deque_top.sv
verif/cdq_checker.sv
verif/tb.sv
